/* src/inversion_pair_counter_defines.svh */
// ----------------------------------------------------------------------------
// Inversion pair counter assertion macros
// Shared concurrent assertion helpers, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef INVERSION_PAIR_COUNTER_DEFINES_SVH
`define INVERSION_PAIR_COUNTER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define IPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define IPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ipc_pkg.sv */
// ----------------------------------------------------------------------------
// Inversion pair counter package
// Shared constants and the control flags that travel along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

    localparam int MAX_ITEMS_DEFAULT = 256;

    localparam int KEY_W   = 32;
    localparam int TOTAL_W = 15;
    localparam int SUM_W   = TOTAL_W + 1;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [KEY_W-1:0]   SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

    // Control flags of one request as it moves down the row.
    typedef struct packed {
        logic valid;  // slot holds a request
        logic last;   // final value of the sequence
        logic skip;   // arrived beyond capacity: neither compared nor stored
    } ipc_flags_t;

endpackage

`default_nettype wire

/* src/ipc_cell.sv */
// ----------------------------------------------------------------------------
// Inversion pair counter cell
// Holds one stored value, compares each passing request against it and
// hands the request on to the next cell through its registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_cell #(
    parameter int CELL_IDX = 0,
    parameter int IW       = 8,
    parameter int CW       = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     adv,
    input  wire ipc_pkg::ipc_flags_t      in_flags,
    input  wire logic [ipc_pkg::KEY_W-1:0] in_key,
    input  wire logic [IW-1:0]            in_idx,
    input  wire logic [CW-1:0]            in_cnt,
    output      ipc_pkg::ipc_flags_t      out_flags,
    output      logic [ipc_pkg::KEY_W-1:0] out_key,
    output      logic [IW-1:0]            out_idx,
    output      logic [CW-1:0]            out_cnt
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    ipc_pkg::ipc_flags_t             flags_reg;
    logic [ipc_pkg::KEY_W-1:0]       key_reg;
    logic [IW-1:0]                   idx_reg;
    logic [CW-1:0]                   cnt_reg;
    logic [CW-1:0]                   cnt_next;
    logic [ipc_pkg::KEY_W-1:0]       stored_reg;
    logic                            live;
    logic                            hit_cmp;
    logic                            hit_store;

    // The slot at a position below the request's index was written earlier in
    // the same sequence; the slot at its index is the one it fills.
    assign live      = in_flags.valid && !in_flags.skip;
    assign hit_cmp   = live && (MY_IDX < in_idx) && (stored_reg > in_key);
    assign hit_store = live && (in_idx == MY_IDX);
    assign cnt_next  = in_cnt + CW'(hit_cmp);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (adv) begin
            flags_reg <= in_flags;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg <= in_key;
            idx_reg <= in_idx;
            cnt_reg <= cnt_next;
            if (hit_store) begin
                stored_reg <= in_key;
            end
        end
    end

    assign out_flags = flags_reg;
    assign out_key   = key_reg;
    assign out_idx   = idx_reg;
    assign out_cnt   = cnt_reg;

endmodule

`default_nettype wire

/* src/ipc_accum.sv */
// ----------------------------------------------------------------------------
// Inversion pair counter accumulator
// Adds each finished request's count to the saturating running total and
// presents the total in the output register on the last value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "inversion_pair_counter_defines.svh"

module ipc_accum #(
    parameter int CW = 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire ipc_pkg::ipc_flags_t         tail_flags,
    input  wire logic [CW-1:0]               tail_cnt,
    output      logic                        adv,
    output      logic                        m_valid,
    input  wire logic                        m_ready,
    output      logic [ipc_pkg::TOTAL_W-1:0] m_pair_count,
    output      logic                        m_overflow
);

    logic [ipc_pkg::TOTAL_W-1:0] total_reg;
    logic                        ovf_reg;
    logic                        m_valid_reg;
    logic [ipc_pkg::TOTAL_W-1:0] pair_count_reg;
    logic                        overflow_reg;
    logic [ipc_pkg::SUM_W-1:0]   sum_wide;
    logic [ipc_pkg::TOTAL_W-1:0] total_next;
    logic                        ovf_next;
    logic                        step;
    logic                        load;

    // The whole row moves only when the output register can take a result.
    assign adv  = !m_valid_reg || m_ready;
    assign step = adv && tail_flags.valid;
    assign load = step && tail_flags.last;

    assign sum_wide   = {1'b0, total_reg} + ipc_pkg::SUM_W'(tail_cnt);
    assign total_next = sum_wide[ipc_pkg::TOTAL_W] ? ipc_pkg::TOTAL_MAX
                                                   : sum_wide[ipc_pkg::TOTAL_W-1:0];
    assign ovf_next   = ovf_reg || tail_flags.skip;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                total_reg   <= '0;
                ovf_reg     <= 1'b0;
                m_valid_reg <= 1'b1;
            end else begin
                if (step) begin
                    total_reg <= total_next;
                    ovf_reg   <= ovf_next;
                end
                if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pair_count_reg <= total_next;
            overflow_reg   <= ovf_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pair_count = pair_count_reg;
    assign m_overflow   = overflow_reg;

    `IPC_ASSERT_NEXT(a_total_cleared, load, (total_reg == '0) && !ovf_reg, "total not cleared after last value")
    `IPC_ASSERT(a_result_source, $rose(m_valid_reg) |-> $past(load), "result raised without a last value")
    `IPC_ASSERT_NEXT(a_stall_holds, m_valid_reg && !m_ready, m_valid_reg && $stable(pair_count_reg), "result lost under stall")

endmodule

`default_nettype wire

/* src/inversion_pair_counter.sv */
// ----------------------------------------------------------------------------
// Inversion pair counter
// Counts pairs of earlier-greater values in a stream of signed 32-bit values.
// ----------------------------------------------------------------------------
// Usage: each request on the slave channel carries one signed value in
// s_tdata; s_tlast marks the final value of a sequence. For every sequence the
// block returns one result on the master channel: the number of pairs whose
// earlier value is strictly greater than the later one (m_tdata, saturating
// at 32767) and an overflow flag (m_tuser) set when values beyond MAX_ITEMS
// arrived and were ignored. Values that are not last produce no result.
// Throughput is one value per cycle while the receiver does not stall: values
// walk down a row of MAX_ITEMS compare cells, one cell per cycle, so several
// values and several sequences may be in flight at once. After the last value
// is accepted, the result passes through the cell row and then the output
// register. When the receiver stalls, the finished result waits in the output
// register and the whole row freezes, so s_tready falls until it is taken.
// Reset clears all control state; the stored values need no clearing, as a
// cell is only compared against once it has been written in the sequence.
// ----------------------------------------------------------------------------
`default_nettype none

`include "inversion_pair_counter_defines.svh"

module inversion_pair_counter #(
    parameter int MAX_ITEMS = ipc_pkg::MAX_ITEMS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Value requests
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value (signed)
    input  wire logic        s_tlast,   // last
    // Results
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [15:0] m_tdata,   // [14:0] pair_count, [15] zero fill
    output      logic        m_tuser    // overflow
);

    // Index of a slot in the row, count of greater values seen by one value,
    // and the fill counter that must also hold MAX_ITEMS itself.
    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = IW;
    localparam int NW = $clog2(MAX_ITEMS + 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(MAX_ITEMS);

    logic                        adv;
    logic                        accept;
    logic [NW-1:0]               item_cnt_reg;
    logic [NW-1:0]               item_cnt_next;
    logic                        full;
    ipc_pkg::ipc_flags_t         head_flags;
    logic [ipc_pkg::KEY_W-1:0]   head_key;

    ipc_pkg::ipc_flags_t         chain_flags [0:MAX_ITEMS];
    logic [ipc_pkg::KEY_W-1:0]   chain_key   [0:MAX_ITEMS];
    logic [IW-1:0]               chain_idx   [0:MAX_ITEMS];
    logic [CW-1:0]               chain_cnt   [0:MAX_ITEMS];

    logic [ipc_pkg::TOTAL_W-1:0] pair_count;

    assign s_tready = adv;
    assign accept   = s_tvalid && s_tready;
    assign full     = (item_cnt_reg == FULL_CNT);

    // Flipping the sign bit turns the signed order into the unsigned order.
    assign head_key         = s_tdata ^ ipc_pkg::SIGN_FLIP;
    assign head_flags.valid = accept;
    assign head_flags.last  = s_tlast;
    assign head_flags.skip  = full;

    // A new sequence starts after the last value; values past capacity are
    // not counted so the fill counter stops at MAX_ITEMS.
    always_comb begin
        item_cnt_next = item_cnt_reg;
        if (accept) begin
            if (s_tlast) begin
                item_cnt_next = '0;
            end else if (!full) begin
                item_cnt_next = item_cnt_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_cnt_reg <= '0;
        end else begin
            item_cnt_reg <= item_cnt_next;
        end
    end

    assign chain_flags[0] = head_flags;
    assign chain_key[0]   = head_key;
    assign chain_idx[0]   = item_cnt_reg[IW-1:0];
    assign chain_cnt[0]   = '0;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        ipc_cell #(
            .CELL_IDX (g),
            .IW       (IW),
            .CW       (CW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_flags  (chain_flags[g]),
            .in_key    (chain_key[g]),
            .in_idx    (chain_idx[g]),
            .in_cnt    (chain_cnt[g]),
            .out_flags (chain_flags[g+1]),
            .out_key   (chain_key[g+1]),
            .out_idx   (chain_idx[g+1]),
            .out_cnt   (chain_cnt[g+1])
        );
    end

    ipc_accum #(
        .CW (CW)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tail_flags   (chain_flags[MAX_ITEMS]),
        .tail_cnt     (chain_cnt[MAX_ITEMS]),
        .adv          (adv),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_pair_count (pair_count),
        .m_overflow   (m_tuser)
    );

    assign m_tdata = {1'b0, pair_count};

    `IPC_ASSERT(a_fill_bound, item_cnt_reg <= FULL_CNT, "fill counter beyond capacity")
    `IPC_ASSERT_NEXT(a_restart, accept && s_tlast, item_cnt_reg == '0, "fill counter not restarted")

endmodule

`default_nettype wire
